// ----- sv/rti_pkg.sv -----
`default_nettype none

package rti_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int INDEX_WIDTH = 16;
  localparam int DIR_WIDTH   = 32;
  localparam int DIR_FRAC    = 30;
  localparam int NUM_REGS    = 8;
  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam int PADDR_WIDTH = REG_AW + 2;
  localparam int PDATA_WIDTH = 32;

  typedef enum logic [REG_AW-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_T_LOWER,
    REG_T_UPPER
  } reg_idx_t;

  localparam logic [PDATA_WIDTH-1:0] DIR_Z_RESET = PDATA_WIDTH'(1) << DIR_FRAC;
  localparam logic [PDATA_WIDTH-1:0] T_UPPER_RESET =
    PDATA_WIDTH'({(COORD_WIDTH-1){1'b1}});

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
    logic [INDEX_WIDTH-1:0]        quad_row;
    logic [INDEX_WIDTH-1:0]        quad_col;
    logic                          tri_index;
  } in_word_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] hit_t;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [INDEX_WIDTH-1:0]        out_row;
    logic [INDEX_WIDTH-1:0]        out_col;
    logic                          out_tri;
  } out_word_t;

endpackage

`default_nettype wire

// ----- sv/rti_mul.sv -----
`default_nettype none

module rti_mul #(
  parameter int AW  = 33,
  parameter int BW  = 67,
  parameter int CHW = 32
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [AW-1:0]   a,
  input  logic signed [BW-1:0]   b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NC  = (BW + CHW - 1) / CHW;
  localparam int XW  = NC * CHW;
  localparam int PPW = AW + CHW + 1;
  localparam int SW  = AW + XW;

  logic signed [XW-1:0]    bx;
  logic signed [CHW:0]     chunk [NC];
  logic signed [PPW-1:0]   pp_nxt [NC];
  logic signed [PPW-1:0]   pp_r [NC];
  logic signed [SW-1:0]    acc;
  logic signed [AW+BW-1:0] p_r;

  assign bx = XW'(b);

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      if (k == NC - 1) begin
        chunk[k] = $signed({bx[XW-1], bx[k*CHW +: CHW]});
      end else begin
        chunk[k] = $signed({1'b0, bx[k*CHW +: CHW]});
      end
      pp_nxt[k] = PPW'(a) * PPW'(chunk[k]);
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NC; k++) begin
      acc = acc + (SW'(pp_r[k]) <<< (k * CHW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      p_r  <= acc[AW+BW-1:0];
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ----- sv/rti_div.sv -----
`default_nettype none

module rti_div #(
  parameter int NUMW = 135,
  parameter int DENW = 102,
  parameter int QW   = 34
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   quo
);

  logic [DENW-1:0] rem_r [QW];
  logic [DENW-1:0] den_r [QW];
  logic [QW-1:0]   qn_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DENW-1:0] rin;
    logic [DENW-1:0] din;
    logic [QW-1:0]   qin;
    logic [DENW:0]   trial;
    logic [DENW:0]   diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign rin = DENW'(num[NUMW-1:QW]);
      assign qin = num[QW-1:0];
      assign din = den;
    end else begin : g_next
      assign rin = rem_r[i-1];
      assign qin = qn_r[i-1];
      assign din = den_r[i-1];
    end

    assign trial = {rin, qin[QW-1]};
    assign diff  = trial - {1'b0, din};
    assign ge    = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
        den_r[i] <= din;
        qn_r[i]  <= {qin[QW-2:0], ge};
      end
    end
  end

  assign quo = qn_r[QW-1];

endmodule

`default_nettype wire

// ----- sv/ray_triangle_intersect_unit.sv -----
// Throughput: one triangle per cycle while the output is not stalled by
// out_ready; the 34-stage restoring dividers and the split wide multipliers
// are fully pipelined, one stage per register.
// Reset (rst_n low, synchronous): drops all words in flight, clears out_valid
// and loads the ray registers with their defaults; datapath registers keep data.
`default_nettype none

module ray_triangle_intersect_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rti_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rti_pkg::out_word_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rti_pkg::PADDR_WIDTH-1:0]     paddr,
  input  logic [rti_pkg::PDATA_WIDTH-1:0]     pwdata,
  output logic [rti_pkg::PDATA_WIDTH-1:0]     prdata,
  output logic                                pready
);

  localparam int CW   = rti_pkg::COORD_WIDTH;
  localparam int DW   = rti_pkg::DIR_WIDTH;
  localparam int IW   = rti_pkg::INDEX_WIDTH;
  localparam int EW   = CW + 1;
  localparam int AXW  = (EW > DW) ? EW : DW;
  localparam int PW   = DW + EW + 1;
  localparam int QXW  = 2 * EW + 1;
  localparam int BXW  = (PW > QXW) ? PW : QXW;
  localparam int NW   = AXW + BXW + 2;
  localparam int MW   = AXW + NW;
  localparam int QW   = CW + 2;
  localparam int NUMW = MW + 1;
  localparam int LAT  = QW + 11;
  localparam int HIT_STAGE = 9;

  localparam logic signed [CW+2:0] SAT_HI = {4'b0000, {(CW-1){1'b1}}};
  localparam logic signed [CW+2:0] SAT_LO = {4'b1111, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic          tri_n;
    logic          hit;
    logic [3:0]    neg;
  } side_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+2:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // configuration registers
  logic [rti_pkg::PDATA_WIDTH-1:0] cfg_r [rti_pkg::NUM_REGS];
  logic signed [CW-1:0] org [3];
  logic signed [DW-1:0] dv [3];
  logic signed [CW-1:0] tlo;
  logic signed [CW-1:0] thi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rti_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
      cfg_r[rti_pkg::REG_DIR_Z]   <= rti_pkg::DIR_Z_RESET;
      cfg_r[rti_pkg::REG_T_UPPER] <= rti_pkg::T_UPPER_RESET;
    end else if (psel && penable && pwrite) begin
      cfg_r[paddr[rti_pkg::PADDR_WIDTH-1:2]] <= pwdata;
    end
  end

  assign prdata = cfg_r[paddr[rti_pkg::PADDR_WIDTH-1:2]];
  assign pready = 1'b1;

  assign org[0] = cfg_r[rti_pkg::REG_ORIGIN_X][CW-1:0];
  assign org[1] = cfg_r[rti_pkg::REG_ORIGIN_Y][CW-1:0];
  assign org[2] = cfg_r[rti_pkg::REG_ORIGIN_Z][CW-1:0];
  assign dv[0]  = cfg_r[rti_pkg::REG_DIR_X][DW-1:0];
  assign dv[1]  = cfg_r[rti_pkg::REG_DIR_Y][DW-1:0];
  assign dv[2]  = cfg_r[rti_pkg::REG_DIR_Z][DW-1:0];
  assign tlo    = cfg_r[rti_pkg::REG_T_LOWER][CW-1:0];
  assign thi    = cfg_r[rti_pkg::REG_T_UPPER][CW-1:0];

  // flow control
  logic [LAT-1:0] v_r;
  side_t          side_r [LAT];
  logic           out_valid_r;
  rti_pkg::out_word_t out_data_r;
  rti_pkg::out_word_t out_nxt;
  logic           en;
  logic           out_en;
  logic           hit9_nxt;
  logic [3:0]     neg9_nxt;

  assign out_en   = !out_valid_r || out_ready;
  assign en       = !v_r[LAT-1] || out_en;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LAT; k++) begin
        if (k == 0) begin
          side_r[k] <= '{row: in_data.quad_row, col: in_data.quad_col,
                         tri_n: in_data.tri_index, hit: 1'b0, neg: 4'b0000};
        end else if (k == HIT_STAGE) begin
          side_r[k] <= '{row: side_r[k-1].row, col: side_r[k-1].col,
                         tri_n: side_r[k-1].tri_n, hit: hit9_nxt, neg: neg9_nxt};
        end else begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  // stage 0: edges and origin offset
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [CW-1:0] vc [3];
  logic signed [EW-1:0] e1_r [3][3];
  logic signed [EW-1:0] e2_r [3][3];
  logic signed [EW-1:0] s_r  [3][3];

  assign va = '{in_data.a_x, in_data.a_y, in_data.a_z};
  assign vb = '{in_data.b_x, in_data.b_y, in_data.b_z};
  assign vc = '{in_data.c_x, in_data.c_y, in_data.c_z};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[0][i] <= EW'(vb[i]) - EW'(va[i]);
        e2_r[0][i] <= EW'(vc[i]) - EW'(va[i]);
        s_r[0][i]  <= EW'(org[i]) - EW'(va[i]);
        for (int st = 1; st < 3; st++) begin
          e1_r[st][i] <= e1_r[st-1][i];
          e2_r[st][i] <= e2_r[st-1][i];
          s_r[st][i]  <= s_r[st-1][i];
        end
      end
    end
  end

  // stage 1: cross product terms P = D x E2, Q = S x E1
  logic signed [BXW-2:0] dax [3];
  logic signed [BXW-2:0] e1x [3];
  logic signed [BXW-2:0] e2x [3];
  logic signed [BXW-2:0] sx  [3];
  logic signed [BXW-2:0] pa_r [3];
  logic signed [BXW-2:0] pb_r [3];
  logic signed [BXW-2:0] qa_r [3];
  logic signed [BXW-2:0] qb_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dax[i] = (BXW-1)'(dv[i]);
      e1x[i] = (BXW-1)'(e1_r[0][i]);
      e2x[i] = (BXW-1)'(e2_r[0][i]);
      sx[i]  = (BXW-1)'(s_r[0][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= dax[1] * e2x[2];
      pb_r[0] <= dax[2] * e2x[1];
      pa_r[1] <= dax[2] * e2x[0];
      pb_r[1] <= dax[0] * e2x[2];
      pa_r[2] <= dax[0] * e2x[1];
      pb_r[2] <= dax[1] * e2x[0];
      qa_r[0] <= sx[1] * e1x[2];
      qb_r[0] <= sx[2] * e1x[1];
      qa_r[1] <= sx[2] * e1x[0];
      qb_r[1] <= sx[0] * e1x[2];
      qa_r[2] <= sx[0] * e1x[1];
      qb_r[2] <= sx[1] * e1x[0];
    end
  end

  // stage 2: P and Q
  logic signed [BXW-1:0] p_r [3];
  logic signed [BXW-1:0] q_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= BXW'(pa_r[i]) - BXW'(pb_r[i]);
        q_r[i] <= BXW'(qa_r[i]) - BXW'(qb_r[i]);
      end
    end
  end

  // stages 3-4: dot product terms
  logic signed [AXW+BXW-1:0] dt_p [3];
  logic signed [AXW+BXW-1:0] un_p [3];
  logic signed [AXW+BXW-1:0] vn_p [3];
  logic signed [AXW+BXW-1:0] tn_p [3];

  for (genvar g = 0; g < 3; g++) begin : g_dot
    rti_mul #(.AW(AXW), .BW(BXW)) u_det (
      .clk(clk), .en(en), .a(AXW'(e1_r[2][g])), .b(p_r[g]), .p(dt_p[g]));
    rti_mul #(.AW(AXW), .BW(BXW)) u_un (
      .clk(clk), .en(en), .a(AXW'(s_r[2][g])), .b(p_r[g]), .p(un_p[g]));
    rti_mul #(.AW(AXW), .BW(BXW)) u_vn (
      .clk(clk), .en(en), .a(AXW'(dv[g])), .b(q_r[g]), .p(vn_p[g]));
    rti_mul #(.AW(AXW), .BW(BXW)) u_tn (
      .clk(clk), .en(en), .a(AXW'(e2_r[2][g])), .b(q_r[g]), .p(tn_p[g]));
  end

  // stage 5: sums
  logic signed [NW-1:0] det5_r, un5_r, vn5_r, tn5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det5_r <= NW'(dt_p[0]) + NW'(dt_p[1]) + NW'(dt_p[2]);
      un5_r  <= NW'(un_p[0]) + NW'(un_p[1]) + NW'(un_p[2]);
      vn5_r  <= NW'(vn_p[0]) + NW'(vn_p[1]) + NW'(vn_p[2]);
      tn5_r  <= NW'(tn_p[0]) + NW'(tn_p[1]) + NW'(tn_p[2]);
    end
  end

  // stage 6: make det positive
  logic signed [NW-1:0] det6_r, un6_r, vn6_r, tn6_r;
  logic                 nz6_r;
  logic                 dneg;

  assign dneg = det5_r[NW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      det6_r <= dneg ? -det5_r : det5_r;
      un6_r  <= dneg ? -un5_r  : un5_r;
      vn6_r  <= dneg ? -vn5_r  : vn5_r;
      tn6_r  <= dneg ? -tn5_r  : tn5_r;
      nz6_r  <= |det5_r;
    end
  end

  // stage 7: barycentric tests; window and point products start
  logic signed [NW:0]   uv_sum;
  logic                 ok7_r, ok8_r;
  logic signed [NW-1:0] tn7_r, tn8_r, det7_r, det8_r;
  logic signed [MW-1:0] lo_p, hi_p;
  logic signed [MW-1:0] tnd_p [3];

  assign uv_sum = (NW+1)'(un6_r) + (NW+1)'(vn6_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ok7_r  <= nz6_r && !un6_r[NW-1] && !vn6_r[NW-1] && ((NW+1)'(det6_r) >= uv_sum);
      tn7_r  <= tn6_r;
      det7_r <= det6_r;
      ok8_r  <= ok7_r;
      tn8_r  <= tn7_r;
      det8_r <= det7_r;
    end
  end

  rti_mul #(.AW(AXW), .BW(NW)) u_lo (
    .clk(clk), .en(en), .a(AXW'(tlo)), .b(det6_r), .p(lo_p));
  rti_mul #(.AW(AXW), .BW(NW)) u_hi (
    .clk(clk), .en(en), .a(AXW'(thi)), .b(det6_r), .p(hi_p));

  for (genvar g = 0; g < 3; g++) begin : g_pt
    rti_mul #(.AW(AXW), .BW(NW)) u_tnd (
      .clk(clk), .en(en), .a(AXW'(dv[g])), .b(tn6_r), .p(tnd_p[g]));
  end

  // stage 9: window test, numerator magnitudes
  logic signed [MW-1:0] tn30;
  logic signed [MW-1:0] num [4];
  logic [MW-1:0]        mag9_r [4];
  logic signed [NW-1:0] det9_r;

  assign tn30 = MW'(tn8_r) <<< rti_pkg::DIR_FRAC;
  assign num  = '{tn30, tnd_p[0], tnd_p[1], tnd_p[2]};
  assign hit9_nxt = ok8_r && (tn30 >= lo_p) && (hi_p >= tn30);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg9_nxt[k] = num[k][MW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mag9_r[k] <= neg9_nxt[k] ? -num[k] : num[k];
      end
      det9_r <= det8_r;
    end
  end

  // stage 10: rounded-division operands
  logic [NUMW-1:0] nd_r [4];
  logic [NW-1:0]   den_r;
  logic [QW-1:0]   quo [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        nd_r[k] <= (NUMW'(mag9_r[k]) << 1) + NUMW'(det9_r);
      end
      den_r <= NW'(det9_r) << 1;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    rti_div #(.NUMW(NUMW), .DENW(NW), .QW(QW)) u_div (
      .clk(clk), .en(en), .num(nd_r[g]), .den(den_r), .quo(quo[g]));
  end

  // output word
  logic signed [CW+2:0] qs [4];
  side_t                sl;

  assign sl = side_r[LAT-1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qs[k] = sl.neg[k] ? (CW+3)'(0) - (CW+3)'(quo[k]) : (CW+3)'(quo[k]);
    end
    out_nxt.hit     = sl.hit;
    out_nxt.hit_t   = sl.hit ? sat(qs[0]) : '0;
    out_nxt.point_x = sl.hit ? sat((CW+3)'(org[0]) + qs[1]) : '0;
    out_nxt.point_y = sl.hit ? sat((CW+3)'(org[1]) + qs[2]) : '0;
    out_nxt.point_z = sl.hit ? sat((CW+3)'(org[2]) + qs[3]) : '0;
    out_nxt.out_row = sl.row;
    out_nxt.out_col = sl.col;
    out_nxt.out_tri = sl.tri_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- sv/rti_checker.sv -----
`default_nettype none

module rti_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input rti_pkg::out_word_t              out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_t == '0 && out_data.point_x == '0
      && out_data.point_y == '0 && out_data.point_z == '0)
    else $error("miss carries nonzero distance or point");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word survives reset");

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (.*);

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  typedef logic signed [255:0] wide_t;

  class hit_scoreboard;
    logic [31:0] ray_regs [NUM_REGS];
    out_word_t   expected_q [$];
    int          errors;

    function new();
      errors = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      for (int i = 0; i < NUM_REGS; i++) ray_regs[i] = '0;
      ray_regs[REG_DIR_Z]   = DIR_Z_RESET;
      ray_regs[REG_T_UPPER] = T_UPPER_RESET;
    endfunction

    function wide_t sx(logic signed [31:0] x);
      return wide_t'(x);
    endfunction

    function wide_t round_div(wide_t n, wide_t d);
      wide_t m, q;
      m = (n < 0) ? -n : n;
      q = (2 * m + d) / (2 * d);
      return (n < 0) ? -q : q;
    endfunction

    function logic [31:0] clamp(wide_t v);
      if (v >= wide_t'(32'sh7fffffff)) return 32'h7fffffff;
      if (v < -wide_t'(64'sh80000000)) return 32'h80000000;
      return v[31:0];
    endfunction

    function void note_triangle(in_word_t w);
      wide_t a[3], b[3], c[3], o[3], d[3], e1[3], e2[3], s[3], p[3], q[3];
      wide_t det, un, vn, tn, tn30, tlo, thi;
      out_word_t r;
      a = '{sx(w.a_x), sx(w.a_y), sx(w.a_z)};
      b = '{sx(w.b_x), sx(w.b_y), sx(w.b_z)};
      c = '{sx(w.c_x), sx(w.c_y), sx(w.c_z)};
      for (int i = 0; i < 3; i++) begin
        o[i]  = sx(ray_regs[i]);
        d[i]  = sx(ray_regs[3 + i]);
        e1[i] = b[i] - a[i];
        e2[i] = c[i] - a[i];
        s[i]  = o[i] - a[i];
      end
      tlo = sx(ray_regs[REG_T_LOWER]);
      thi = sx(ray_regs[REG_T_UPPER]);
      p[0] = d[1] * e2[2] - d[2] * e2[1];
      p[1] = d[2] * e2[0] - d[0] * e2[2];
      p[2] = d[0] * e2[1] - d[1] * e2[0];
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
      un  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
      vn  = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
      tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
      r = '0;
      if (det != 0) begin
        if (det < 0) begin
          det = -det;
          un  = -un;
          vn  = -vn;
          tn  = -tn;
        end
        tn30 = tn <<< DIR_FRAC;
        if (un >= 0 && vn >= 0 && det >= un + vn && tn30 >= tlo * det && thi * det >= tn30)
        begin
          r.hit     = 1'b1;
          r.hit_t   = clamp(round_div(tn30, det));
          r.point_x = clamp(o[0] + round_div(tn * d[0], det));
          r.point_y = clamp(o[1] + round_div(tn * d[1], det));
          r.point_z = clamp(o[2] + round_div(tn * d[2], det));
        end
      end
      r.out_row = w.quad_row;
      r.out_col = w.quad_col;
      r.out_tri = w.tri_index;
      expected_q = {expected_q, r};
    endfunction

    function void check_result(out_word_t g);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", g);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (g.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, g.hit); errors++;
      end
      if (g.hit_t !== e.hit_t) begin
        $error("hit_t exp %0d got %0d", e.hit_t, g.hit_t); errors++;
      end
      if (g.point_x !== e.point_x) begin
        $error("point_x exp %0d got %0d", e.point_x, g.point_x); errors++;
      end
      if (g.point_y !== e.point_y) begin
        $error("point_y exp %0d got %0d", e.point_y, g.point_y); errors++;
      end
      if (g.point_z !== e.point_z) begin
        $error("point_z exp %0d got %0d", e.point_z, g.point_z); errors++;
      end
      if (g.out_row !== e.out_row) begin
        $error("out_row exp %0d got %0d", e.out_row, g.out_row); errors++;
      end
      if (g.out_col !== e.out_col) begin
        $error("out_col exp %0d got %0d", e.out_col, g.out_col); errors++;
      end
      if (g.out_tri !== e.out_tri) begin
        $error("out_tri exp %0d got %0d", e.out_tri, g.out_tri); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic pready;

  hit_scoreboard sb = new();
  int  out_wait = 0;
  int  idle_cycles = 0;
  bit  calm = 0;

  ray_triangle_intersect_unit u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_triangle(in_data);
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
      out_wait = calm ? 0 : $urandom_range(0, 13);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_ready <= 1'b0;
      out_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.ray_regs[r] = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, tlo, thi);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_T_LOWER, tlo);
    write_reg(REG_T_UPPER, thi);
  endtask

  task automatic push_triangle(in_word_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_off(int span);
    return $unsigned($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic in_word_t random_triangle();
    in_word_t w;
    logic [351:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t aimed_triangle();
    in_word_t w;
    logic signed [63:0] h[3], t;
    logic signed [31:0] u[3], v[3];
    int span;
    w = random_triangle();
    t = 64'($urandom_range(0, 1 << 18));
    span = 1 << $urandom_range(2, 20);
    for (int i = 0; i < 3; i++) begin
      h[i] = $signed(sb.ray_regs[i]) + ((t * $signed(sb.ray_regs[3 + i])) >>> DIR_FRAC);
      u[i] = rnd_off(span);
      v[i] = rnd_off(span);
    end
    case ($urandom_range(0, 5))
      0: begin
        u[0] = 0; u[1] = 0; u[2] = 0;
      end
      1: begin
        v[0] = -u[0]; v[1] = -u[1]; v[2] = -u[2];
      end
      default: ;
    endcase
    w.a_x = 32'(h[0] + u[0]); w.a_y = 32'(h[1] + u[1]); w.a_z = 32'(h[2] + u[2]);
    w.b_x = 32'(h[0] + v[0]); w.b_y = 32'(h[1] + v[1]); w.b_z = 32'(h[2] + v[2]);
    w.c_x = 32'(h[0] - u[0] - v[0]);
    w.c_y = 32'(h[1] - u[1] - v[1]);
    w.c_z = 32'(h[2] - u[2] - v[2]);
    if ($urandom_range(0, 9) == 0) begin
      w.b_x = w.a_x; w.b_y = w.a_y; w.b_z = w.a_z;
    end
    return w;
  endfunction

  task automatic random_phase(int n);
    in_word_t w;
    calm = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) calm = !calm;
      w = ($urandom_range(0, 9) < 7) ? aimed_triangle() : random_triangle();
      push_triangle(w);
    end
    drain();
  endtask

  function automatic in_word_t tri_of(int ax, ay, az, bx, by, bz, cx, cy, cz);
    in_word_t w;
    w = {ax, ay, az, bx, by, bz, cx, cy, cz, 16'($urandom), 16'($urandom), 1'($urandom)};
    return w;
  endfunction

  function automatic logic [31:0] rnd_dir_z();
    return $unsigned($signed($urandom_range(0, 32'hc0000000)) + 32'sh80000000);
  endfunction

  initial begin
    in_word_t w;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_triangle(tri_of(-256, -256, 2560, 512, -256, 2560, -256, 512, 2560));
    push_triangle(tri_of(0, 0, 1280, 512, 0, 1280, 0, 512, 1280));
    push_triangle(tri_of(-256, 0, 1280, 256, 0, 1280, 0, 256, 1280));
    push_triangle(tri_of(0, 0, 0, 0, 256, 256, 0, -256, 256));
    push_triangle(tri_of(-256, -256, 768, -256, -256, 768, 512, 512, 768));
    push_triangle(tri_of(-256, -256, -768, 512, -256, -768, -256, 512, -768));
    push_triangle(tri_of(-256, -256, 0, 512, -256, 0, -256, 512, 0));
    w = '1;
    push_triangle(w);
    w = '0;
    push_triangle(w);
    w = {{9{32'h80000000}}, 16'hffff, 16'h0000, 1'b1};
    push_triangle(w);
    w = {32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
         32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'h0000, 16'hffff, 1'b0};
    push_triangle(w);
    push_triangle(tri_of(-1 << 30, -1 << 30, 1 << 30, 1 << 30, -1 << 30, 1 << 30,
                         0, 1 << 30, 1 << 30));
    drain();

    random_phase(180);

    set_ray(rnd_off(1 << 16), rnd_off(1 << 16), rnd_off(1 << 16),
            $urandom, $urandom, rnd_dir_z(), 0, 32'h7fffffff);
    random_phase(180);

    set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 32'h40000000, 32'h80000000, 32'h7fffffff);
    random_phase(120);

    set_ray(32'h80000000, 32'h7fffffff, 32'h80000000,
            32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    random_phase(120);

    set_ray(rnd_off(1 << 12), rnd_off(1 << 12), rnd_off(1 << 12),
            $urandom, $urandom, rnd_dir_z(), 100, -100);
    random_phase(100);

    set_ray(rnd_off(1 << 12), rnd_off(1 << 12), 0, 0, 0, 0, 32'h80000000, 32'h7fffffff);
    random_phase(60);

    set_ray(rnd_off(1 << 10), rnd_off(1 << 10), rnd_off(1 << 10),
            $urandom, $urandom, rnd_dir_z(), 1 << 16, 1 << 17);
    random_phase(180);

    set_ray(rnd_off(1 << 20), rnd_off(1 << 20), rnd_off(1 << 20),
            $urandom, $urandom, rnd_dir_z(), rnd_off(1 << 10), 32'h7fffffff);
    random_phase(200);

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
